FILE: rtl/earliest_key_quantity_drain_assert.svh
// ----------------------------------------------------------------------------
// earliest_key_quantity_drain assertion macros
// shared concurrent assertion forms, reset low disables checking
// ----------------------------------------------------------------------------
`ifndef EARLIEST_KEY_QUANTITY_DRAIN_ASSERT_SVH
`define EARLIEST_KEY_QUANTITY_DRAIN_ASSERT_SVH

// same-cycle implication
`define EKQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ekq assertion failed");

// next-cycle implication
`define EKQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ekq assertion failed");

// condition must never hold
`define EKQ_ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("ekq assertion failed");

`endif

FILE: rtl/ekq_pkg.sv
// ----------------------------------------------------------------------------
// ekq_pkg
// constants, codes and types shared by the lot chain and its control
// ----------------------------------------------------------------------------
`default_nettype none

package ekq_pkg;

    localparam int LOT_DEPTH = 16;
    localparam int KEY_BITS  = 31;
    localparam int QTY_BITS  = 16;
    localparam int CNT_BITS  = $clog2(LOT_DEPTH + 1);

    localparam int STATUS_BITS = 2;
    localparam int S_DATA_BITS = ((KEY_BITS + QTY_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = STATUS_BITS + QTY_BITS + CNT_BITS;
    localparam int M_DATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    localparam logic KIND_INSERT   = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_SHORT = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_SUB
    } cell_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t                op;
        logic [KEY_BITS-1:0]     key;
        logic [QTY_BITS-1:0]     qty;
    } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/ekq_cell.sv
// ----------------------------------------------------------------------------
// ekq_cell
// one lot slot: key and quantity, shifts with its neighbors on insert and pop
// ----------------------------------------------------------------------------
`default_nettype none

module ekq_cell
    import ekq_pkg::*;
(
    input  wire logic                aclk,
    input  wire cell_cmd_t           cmd,
    input  wire logic                head,      // first cell of the row
    input  wire logic                occupied,  // slot holds a lot
    input  wire logic                at_tail,   // first free slot
    input  wire logic                left_gt,
    input  wire logic [KEY_BITS-1:0] left_key,
    input  wire logic [QTY_BITS-1:0] left_qty,
    input  wire logic [KEY_BITS-1:0] right_key,
    input  wire logic [QTY_BITS-1:0] right_qty,
    output logic                     gt,
    output logic [KEY_BITS-1:0]      key,
    output logic [QTY_BITS-1:0]      qty
);

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [QTY_BITS-1:0] qty_reg, qty_next;

    // strictly greater keeps equal keys first in first out
    assign gt  = occupied && (key_reg > cmd.key);
    assign key = key_reg;
    assign qty = qty_reg;

    always_comb begin
        key_next = key_reg;
        qty_next = qty_reg;
        unique case (cmd.op)
            CELL_INSERT: begin
                if (left_gt) begin
                    key_next = left_key;
                    qty_next = left_qty;
                end else if (gt || at_tail) begin
                    key_next = cmd.key;
                    qty_next = cmd.qty;
                end
            end
            CELL_POP: begin
                key_next = right_key;
                qty_next = right_qty;
            end
            CELL_SUB: begin
                if (head) begin
                    qty_next = qty_reg - cmd.qty;
                end
            end
            CELL_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        qty_reg <= qty_next;
    end

endmodule

`default_nettype wire

FILE: rtl/ekq_chain.sv
// ----------------------------------------------------------------------------
// ekq_chain
// row of lot cells kept in key order, smallest key at the head
// ----------------------------------------------------------------------------
`default_nettype none

module ekq_chain
    import ekq_pkg::*;
(
    input  wire logic                aclk,
    input  wire cell_cmd_t           cmd,
    input  wire logic [CNT_BITS-1:0] lot_count,
    output logic [QTY_BITS-1:0]      head_qty
);

    logic [LOT_DEPTH-1:0] gt_vec;
    logic [KEY_BITS-1:0]  key_vec [LOT_DEPTH];
    logic [QTY_BITS-1:0]  qty_vec [LOT_DEPTH];

    assign head_qty = qty_vec[0];

    for (genvar i = 0; i < LOT_DEPTH; i++) begin : g_cell
        localparam int LEFT  = (i == 0) ? 0 : i - 1;
        localparam int RIGHT = (i == LOT_DEPTH - 1) ? i : i + 1;

        logic cell_left_gt;
        assign cell_left_gt = (i == 0) ? 1'b0 : gt_vec[LEFT];

        ekq_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .head      (i == 0),
            .occupied  (CNT_BITS'(i) < lot_count),
            .at_tail   (CNT_BITS'(i) == lot_count),
            .left_gt   (cell_left_gt),
            .left_key  (key_vec[LEFT]),
            .left_qty  (qty_vec[LEFT]),
            .right_key (key_vec[RIGHT]),
            .right_qty (qty_vec[RIGHT]),
            .gt        (gt_vec[i]),
            .key       (key_vec[i]),
            .qty       (qty_vec[i])
        );
    end

endmodule

`default_nettype wire

FILE: rtl/earliest_key_quantity_drain.sv
// an accepted item is captured, then worked in the work state; an insert finishes in its
//   first work step, a dispatch takes a further step per lot fully used up before the
//   request is met or the table empties, one lot per cycle while the output has room
// a new item is taken as soon as the previous result sits in the output register
// reset: aresetn low clears control, lot count and output valid; lot cells keep
//   their contents, which are never read until written
// ----------------------------------------------------------------------------
// earliest_key_quantity_drain
// sorted lot table in a cell chain, inserts by key, dispatches from the smallest key
// ----------------------------------------------------------------------------
`default_nettype none

`include "earliest_key_quantity_drain_assert.svh"

module earliest_key_quantity_drain
    import ekq_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input channel
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [S_DATA_BITS-1:0] s_tdata,   // lot_key, amount, zero pad
    input  wire logic                   s_tuser,   // kind
    // result channel
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [M_DATA_BITS-1:0]      m_tdata    // status, units_short, lots_held, zero pad
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    // control state
    logic                   state_reg, state_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic                   m_valid_reg, m_valid_next;

    // captured item
    logic                   kind_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [QTY_BITS-1:0]    want_reg, want_next;

    // result register
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic [QTY_BITS-1:0]    short_reg, short_next;
    logic [CNT_BITS-1:0]    held_reg, held_next;

    cell_cmd_t              cmd;
    logic [QTY_BITS-1:0]    head_qty;
    logic                   in_xfer;
    logic                   out_free;
    logic                   finish;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    // result register can take a new value this cycle
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_BITS - M_FIELD_BITS){1'b0}}, held_reg, short_reg, status_reg};

    ekq_chain u_chain (
        .aclk      (aclk),
        .cmd       (cmd),
        .lot_count (count_reg),
        .head_qty  (head_qty)
    );

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        want_next   = want_reg;
        status_next = status_reg;
        short_next  = short_reg;
        held_next   = held_reg;
        finish      = 1'b0;
        cmd.op      = CELL_HOLD;
        cmd.key     = key_reg;
        cmd.qty     = want_reg;

        if (in_xfer) begin
            want_next = s_tdata[KEY_BITS +: QTY_BITS];
            state_next = ST_WORK;
        end

        // one step per cycle, only while the result register has room
        if (state_reg == ST_WORK && out_free) begin
            status_next = STATUS_DONE;
            short_next  = '0;
            if (kind_reg == KIND_INSERT) begin
                finish = 1'b1;
                if (count_reg == CNT_BITS'(LOT_DEPTH)) begin
                    status_next = STATUS_FULL;
                end else begin
                    cmd.op     = CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end else begin
                priority if (count_reg == '0) begin
                    // table empty: whatever is still wanted is reported short
                    finish      = 1'b1;
                    status_next = STATUS_SHORT;
                    short_next  = want_reg;
                end else if (head_qty > want_reg) begin
                    finish = 1'b1;
                    cmd.op = CELL_SUB;
                end else if (head_qty == want_reg) begin
                    finish     = 1'b1;
                    cmd.op     = CELL_POP;
                    count_next = count_reg - 1'b1;
                end else begin
                    // head lot used up, rest comes from the next lot
                    cmd.op     = CELL_POP;
                    count_next = count_reg - 1'b1;
                    want_next  = want_reg - head_qty;
                end
            end
            if (finish) begin
                held_next  = count_next;
                state_next = ST_IDLE;
            end
        end

        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            kind_reg <= s_tuser;
            key_reg  <= s_tdata[KEY_BITS-1:0];
        end
        want_reg   <= want_next;
        status_reg <= status_next;
        short_reg  <= short_next;
        held_reg   <= held_next;
    end

    // table never holds more lots than it has cells
    `EKQ_ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > CNT_BITS'(LOT_DEPTH))
    // an accepted item always puts the block in the work state in the next cycle
    `EKQ_ASSERT_NEXT(a_accept_work, aclk, aresetn, in_xfer, state_reg == ST_WORK)
    // a shortfall leaves the table empty
    `EKQ_ASSERT_IMP(a_short_empty, aclk, aresetn,
        m_valid_reg && status_reg == STATUS_SHORT, held_reg == '0)
    // units short only reported with a shortfall
    `EKQ_ASSERT_IMP(a_short_only, aclk, aresetn,
        m_valid_reg && status_reg != STATUS_SHORT, short_reg == '0)
    // a full-table drop never changes the lot count
    `EKQ_ASSERT_IMP(a_full_hold, aclk, aresetn,
        finish && status_next == STATUS_FULL, count_next == count_reg)

endmodule

`default_nettype wire

FILE: tb/ekq_drain_checker.sv
// ----------------------------------------------------------------------------
// ekq_drain_checker
// watches both stream channels, keeps its own sorted lot table, predicts the
// result of every accepted item and compares it with the block's output
// ----------------------------------------------------------------------------
`default_nettype none

module ekq_drain_checker
    import ekq_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [S_DATA_BITS-1:0] s_tdata,
    input  wire logic                   s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [M_DATA_BITS-1:0] m_tdata,
    output int                          results_pending,
    output int                          fail_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [QTY_BITS-1:0]    units_short;
        logic [CNT_BITS-1:0]    lots_held;
    } drain_result_t;

    logic [KEY_BITS-1:0] lot_keys [LOT_DEPTH];
    logic [QTY_BITS-1:0] lot_qtys [LOT_DEPTH];
    int                  lots_on_hand = 0;
    drain_result_t       expected_results [$];

    initial begin
        results_pending = 0;
        fail_count      = 0;
    end

    // remove the smallest-key lot, shifting the rest down
    function automatic void pop_earliest();
        for (int i = 1; i < lots_on_hand; i++) begin
            lot_keys[i-1] = lot_keys[i];
            lot_qtys[i-1] = lot_qtys[i];
        end
        lots_on_hand--;
    endfunction

    function automatic drain_result_t apply_lot_item(input logic kind,
                                                     input logic [KEY_BITS-1:0] key,
                                                     input logic [QTY_BITS-1:0] amount);
        drain_result_t       r;
        int                  slot;
        logic [QTY_BITS-1:0] wanted;
        bit                  busy;
        bit                  exact;
        r.status      = STATUS_DONE;
        r.units_short = '0;
        if (kind == KIND_INSERT) begin
            if (lots_on_hand >= LOT_DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                // equal keys land behind the existing ones
                slot = lots_on_hand;
                while (slot > 0 && lot_keys[slot-1] > key) begin
                    lot_keys[slot] = lot_keys[slot-1];
                    lot_qtys[slot] = lot_qtys[slot-1];
                    slot--;
                end
                lot_keys[slot] = key;
                lot_qtys[slot] = amount;
                lots_on_hand++;
            end
        end else begin
            wanted = amount;
            busy   = 1'b1;
            while (busy) begin
                if (lots_on_hand == 0) begin
                    r.status      = STATUS_SHORT;
                    r.units_short = wanted;
                    busy          = 1'b0;
                end else if (lot_qtys[0] > wanted) begin
                    lot_qtys[0] = lot_qtys[0] - wanted;
                    busy        = 1'b0;
                end else begin
                    exact  = (lot_qtys[0] == wanted);
                    wanted = wanted - lot_qtys[0];
                    pop_earliest();
                    busy   = !exact;
                end
            end
        end
        r.lots_held = lots_on_hand[CNT_BITS-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        drain_result_t want;
        drain_result_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_lot_item(s_tuser, s_tdata[0 +: KEY_BITS],
                                                          s_tdata[KEY_BITS +: QTY_BITS]));
            end
            if (m_tvalid && m_tready) begin
                got.status      = m_tdata[0 +: STATUS_BITS];
                got.units_short = m_tdata[STATUS_BITS +: QTY_BITS];
                got.lots_held   = m_tdata[STATUS_BITS + QTY_BITS +: CNT_BITS];
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing actual %h",
                             $realtime, got);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("units_short", 32'(want.units_short), 32'(got.units_short));
                    check_field("lots_held", 32'(want.lots_held), 32'(got.lots_held));
                end
            end
            results_pending <= expected_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/earliest_key_quantity_drain_test.sv
// ----------------------------------------------------------------------------
// earliest_key_quantity_drain_test
// drives inserts and dispatches into the lot table with random gaps and
// back-pressure, a directed opening and a long random run; the checker
// beside the block predicts every result and counts mismatches
// ----------------------------------------------------------------------------
`default_nettype none

module earliest_key_quantity_drain_test;

    import ekq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_AT      = 300;     // items sent before the long receiver hold
    localparam int HOLD_CYCLES  = 250;
    localparam int CALM_FROM    = 500;     // random items with no idling on either side
    localparam int CALM_TO      = 700;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PAD_BITS     = S_DATA_BITS - KEY_BITS - QTY_BITS;

    localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
    localparam logic [QTY_BITS-1:0] QTY_MAX = '1;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata;       // lot_key, amount, zero pad
    logic                   s_tuser;       // kind
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_BITS-1:0] m_tdata;       // status, units_short, lots_held, zero pad

    int results_pending;
    int fail_count;
    int items_sent  = 0;
    int stall_left  = 0;
    int cycle_count = 0;
    bit hold_done   = 1'b0;
    bit calm        = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    earliest_key_quantity_drain u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ekq_drain_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .results_pending (results_pending),
        .fail_count      (fail_count)
    );

    // receiver: random stalls, one long hold so the block backs up into its input
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!hold_done && items_sent >= HOLD_AT) begin
            m_tready   <= 1'b0;
            stall_left <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 35);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one transfer on the input channel, with random idle cycles ahead of it
    task automatic send_lot_item(input logic kind, input logic [KEY_BITS-1:0] key,
                                 input logic [QTY_BITS-1:0] amount);
        while (!calm && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{PAD_BITS{1'b0}}, amount, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent <= items_sent + 1;
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60) return KEY_BITS'($urandom_range(31));   // crowded keys, many ties
        if (roll < 90) return KEY_BITS'($urandom());
        return roll[0] ? KEY_MAX : '0;
    endfunction

    function automatic logic [QTY_BITS-1:0] pick_lot_qty();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 80) return QTY_BITS'($urandom_range(40));
        if (roll < 90) return QTY_BITS'($urandom());
        return '0;
    endfunction

    function automatic logic [QTY_BITS-1:0] pick_request();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60) return QTY_BITS'($urandom_range(60));
        if (roll < 85) return QTY_BITS'($urandom_range(200));
        if (roll < 95) return QTY_BITS'($urandom());
        return '0;
    endfunction

    initial begin
        int insert_pct;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= KIND_INSERT;
        s_tdata  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // dispatch on an empty table reports the whole request short, zero too
        send_lot_item(KIND_DISPATCH, '0, '0);
        // largest key and quantity, then a zero-quantity lot at the front
        send_lot_item(KIND_INSERT, KEY_MAX, QTY_MAX);
        send_lot_item(KIND_INSERT, '0, '0);
        // equal keys drain first in, first out
        send_lot_item(KIND_INSERT, 31'd5, 16'd10);
        send_lot_item(KIND_INSERT, 31'd5, 16'd20);
        // zero request removes the empty head lot, then leaves a full one alone
        send_lot_item(KIND_DISPATCH, '0, '0);
        send_lot_item(KIND_DISPATCH, '0, '0);
        // partial, exact, then a request spanning two lots
        send_lot_item(KIND_DISPATCH, '0, 16'd4);
        send_lot_item(KIND_DISPATCH, '0, 16'd6);
        send_lot_item(KIND_DISPATCH, '0, 16'd25);
        // drain the table exactly
        send_lot_item(KIND_DISPATCH, '0, 16'd65530);
        // fill with falling keys so each lot goes in at the front, then overflow
        for (int i = 0; i < LOT_DEPTH; i++) begin
            send_lot_item(KIND_INSERT, KEY_BITS'(1000 - 10 * i), QTY_BITS'(i + 1));
        end
        send_lot_item(KIND_INSERT, '0, 16'd7);
        // request larger than everything held: shortfall, table emptied
        send_lot_item(KIND_DISPATCH, KEY_MAX, QTY_MAX);

        // random part: phases lean toward inserts or dispatches so the table
        // swings between full and empty
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm <= (n >= CALM_FROM && n < CALM_TO);
            case ((n / 100) % 4)
                0:       insert_pct = 75;
                1:       insert_pct = 50;
                2:       insert_pct = 30;
                default: insert_pct = 60;
            endcase
            if ($urandom_range(99) < insert_pct) begin
                send_lot_item(KIND_INSERT, pick_key(), pick_lot_qty());
            end else begin
                send_lot_item(KIND_DISPATCH, pick_key(), pick_request());
            end
        end
        s_tvalid <= 1'b0;

        while (results_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        // every predicted result must have come out
        if (fail_count == 0 && results_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
